### rtl/enms_pkg.sv
`timescale 1ns / 1ps

package enms_pkg;

	// Field widths
	localparam int MAG_W   = 16;
	localparam int ORI_W   = 16;
	localparam int SIZE_W  = 12;
	localparam int ROW_W   = 12;
	localparam int COL_W   = 11;

	// Largest supported row length (line store depth)
	localparam int MAX_WIDTH_DEF = 2048;

	// Register reset values
	localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 12'd640;
	localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 12'd480;

	// Direction thresholds in Q2.14 radians (0.3927 and 1.1781)
	localparam logic [ORI_W:0] THRESH_LOW  = 17'd6434;
	localparam logic [ORI_W:0] THRESH_HIGH = 17'd19302;

	// Configuration register indexes
	localparam int REG_IDX_W = 1;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	// One incoming pixel
	typedef struct packed {
		logic        [MAG_W-1:0] magnitude;
		logic signed [ORI_W-1:0] orientation;
	} pix_t;

	// One result for an interior pixel
	typedef struct packed {
		logic [MAG_W-1:0] kept_value;
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
		logic             last_of_frame;
	} res_t;

endpackage

### rtl/enms_ram.sv
`timescale 1ns / 1ps

module enms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read, old data on a same-address write, hold when idle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/edge_non_maximum_suppression_core.sv
`timescale 1ns / 1ps
// Non-maximum suppression for an edge detector on a raster pixel stream.
// pix channel: one pixel (magnitude, Q2.14 orientation) per request, raster
// order, taken on a clock edge with pix_valid high and pix_stall low.
// res channel: one result per interior pixel (one-pixel border dropped),
// taken on a clock edge with res_valid high and res_stall low. Pixels of
// the first two rows and columns of each frame give no result.
// cfg channel: cfg_ready is always high; index 0 sets frame_width, index 1
// sets frame_height. Write only while the block is idle.
// Throughput: one pixel per clock while pix_stall stays low. A result is
// registered: the line store is read on the edge that takes its pixel,
// and the 3x3 compare loads the result register when stage 1 advances.
// Reset: counters and control registers clear, then a clearing pass writes
// zero to every line store entry, one per cycle, with pix_stall held high;
// configuration writes are taken during that pass.
// A stalled result holds; the input stage keeps taking pixels until the
// one-pixel pipeline stage behind the result register is full as well.
module edge_non_maximum_suppression_core import enms_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_stall,
	input  pix_t              pix_data,
	output logic              res_valid,
	input  logic              res_stall,
	output res_t              res_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  reg_idx_t          cfg_index,
	input  logic [SIZE_W-1:0] cfg_data
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int CMPW = ((CW + 1) > 13) ? (CW + 1) : 13;
	localparam int LW   = 2 * MAG_W + ORI_W;
	localparam logic [CMPW-1:0] MAXW_EXT = CMPW'(MAX_WIDTH);
	localparam logic [CW-1:0]   CLR_LAST = CW'(MAX_WIDTH - 1);

	typedef enum logic [1:0] {
		DIR_HORZ,
		DIR_VERT,
		DIR_RISE,
		DIR_FALL
	} dir_t;

	logic [SIZE_W-1:0] frame_width_q;
	logic [SIZE_W-1:0] frame_height_q;
	logic              clr_q;
	logic [CW-1:0]     clr_addr_q;
	logic [CW-1:0]     col_q;
	logic [ROW_W-1:0]  row_q;

	logic              accept;
	logic              s1_adv;
	logic [CMPW-1:0]   col_nx;
	logic [CMPW-1:0]   fw_ext;
	logic [CMPW-1:0]   width_eff;
	logic              col_wrap;
	logic [ROW_W:0]    row_nx;
	logic              row_wrap;
	logic              emit;
	logic              last;

	logic              valid_s1;
	logic              new_s1;
	logic              emit_s1;
	logic              last_s1;
	logic [MAG_W-1:0]  mag_s1;
	logic [ORI_W-1:0]  ori_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [CW-1:0]     col_s1;
	logic              byp_s1;
	logic [LW-1:0]     byp_data_s1;

	logic [LW-1:0]     ram_rd;
	logic [LW-1:0]     rd_line;
	logic [LW-1:0]     wr_line;
	logic              ram_wr_en;
	logic [CW-1:0]     ram_wr_addr;
	logic [LW-1:0]     ram_wr_data;
	logic [MAG_W-1:0]  ncol [3];
	logic [ORI_W-1:0]  ori_up;

	logic [MAG_W-1:0]  left_q [3];
	logic [MAG_W-1:0]  mid_q [3];
	logic [ORI_W-1:0]  cori_q;

	logic [ORI_W:0]    ori_abs;
	dir_t              dir;
	logic [MAG_W-1:0]  centre;
	logic [MAG_W-1:0]  nb_a;
	logic [MAG_W-1:0]  nb_b;
	logic [MAG_W-1:0]  kept;
	logic [CMPW-1:0]   col_m1;

	logic              res_valid_q;
	res_t              res_data_q;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sweep the line stores to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + CW'(1);
			if (clr_addr_q == CLR_LAST) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Handshake: hold the input during the clearing pass and while the single stage is full and cannot advance
	assign s1_adv    = !res_valid_q || !res_stall;
	assign pix_stall = clr_q || (valid_s1 && !s1_adv);
	assign accept    = pix_valid && !pix_stall;

	// Position counters and border decisions of the incoming pixel
	assign col_nx    = {{(CMPW-CW){1'b0}}, col_q} + CMPW'(1);
	assign fw_ext    = CMPW'(frame_width_q);
	assign width_eff = (fw_ext > MAXW_EXT) ? MAXW_EXT : fw_ext;
	assign col_wrap  = (col_nx >= fw_ext) || (col_nx >= MAXW_EXT);
	assign row_nx    = {1'b0, row_q} + (ROW_W+1)'(1);
	assign row_wrap  = (row_nx >= {1'b0, frame_height_q}) || row_nx[ROW_W];
	assign emit      = (row_q >= ROW_W'(2)) && (col_q >= CW'(2));
	assign last      = (row_nx == {1'b0, frame_height_q}) && (col_nx == width_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_wrap ? '0 : col_nx[CW-1:0];
			if (col_wrap) begin
				row_q <= row_wrap ? '0 : row_nx[ROW_W-1:0];
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			new_s1   <= 1'b0;
			byp_s1   <= 1'b0;
		end else begin
			new_s1 <= accept;
			if (accept) begin
				valid_s1 <= 1'b1;
				byp_s1   <= new_s1 && (col_s1 == col_q);
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1     <= emit;
			last_s1     <= last;
			mag_s1      <= pix_data.magnitude;
			ori_s1      <= pix_data.orientation;
			row_s1      <= row_q;
			col_s1      <= col_q;
			byp_data_s1 <= wr_line;
		end
	end

	// Line stores: older magnitude, newer magnitude, orientation per column
	enms_ram #(
		.WIDTH (LW),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (ram_rd)
	);

	// Forward the previous pixel's write when it hit the same column
	assign rd_line = byp_s1 ? byp_data_s1 : ram_rd;
	assign ncol[0] = rd_line[LW-1 -: MAG_W];
	assign ncol[1] = rd_line[ORI_W +: MAG_W];
	assign ncol[2] = mag_s1;
	assign ori_up  = rd_line[ORI_W-1:0];
	assign wr_line = {ncol[1], mag_s1, ori_s1};

	// Write back once per pixel, in its first cycle in stage 1, or write zeros during the clearing pass
	assign ram_wr_en   = clr_q || new_s1;
	assign ram_wr_addr = clr_q ? clr_addr_q : col_s1;
	assign ram_wr_data = clr_q ? '0 : wr_line;

	// Advance the 3x3 window and the center orientation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				left_q[i] <= '0;
				mid_q[i]  <= '0;
			end
			cori_q <= '0;
		end else if (valid_s1 && s1_adv) begin
			for (int i = 0; i < 3; i++) begin
				left_q[i] <= mid_q[i];
				mid_q[i]  <= ncol[i];
			end
			cori_q <= ori_up;
		end
	end

	// Quantize the center orientation
	assign ori_abs = cori_q[ORI_W-1] ? (~{1'b1, cori_q} + (ORI_W+1)'(1))
	                                 : {1'b0, cori_q};

	always_comb begin
		if (ori_abs <= THRESH_LOW) begin
			dir = DIR_HORZ;
		end else if (ori_abs >= THRESH_HIGH) begin
			dir = DIR_VERT;
		end else if (!cori_q[ORI_W-1]) begin
			dir = DIR_RISE;
		end else begin
			dir = DIR_FALL;
		end
	end

	// Pick the two neighbors along the direction
	assign centre = mid_q[1];

	always_comb begin
		case (dir)
			DIR_HORZ: begin
				nb_a = ncol[1];
				nb_b = left_q[1];
			end
			DIR_VERT: begin
				nb_a = mid_q[0];
				nb_b = mid_q[2];
			end
			DIR_RISE: begin
				nb_a = ncol[2];
				nb_b = left_q[0];
			end
			default: begin
				nb_a = ncol[0];
				nb_b = left_q[2];
			end
		endcase
	end

	// Keep the center only if it is a positive local maximum
	assign kept   = ((centre != '0) && (centre >= nb_a) && (centre >= nb_b)) ? centre : '0;
	assign col_m1 = {{(CMPW-CW){1'b0}}, col_s1} - CMPW'(1);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv) begin
			res_valid_q <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1 && emit_s1) begin
			res_data_q.kept_value    <= kept;
			res_data_q.out_row       <= row_s1 - ROW_W'(1);
			res_data_q.out_col       <= col_m1[COL_W-1:0];
			res_data_q.last_of_frame <= last_s1;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

endmodule

### rtl/enms_checker.sv
`timescale 1ns / 1ps

module enms_assertions import enms_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic pix_stall,
	input logic res_valid,
	input logic res_stall,
	input res_t res_data
);

	// A stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("stalled result dropped");

	// A stalled result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res_data))
		else $error("stalled result changed");

	// Line store clearing blocks input right after reset
	assert property (@(posedge clk)
		$past(!arst_n) |-> pix_stall)
		else $error("pixel taken during line store clearing");

	// Pixels of the first row and column never produce a result
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.out_row != '0) && (res_data.out_col != '0))
		else $error("border pixel emitted");

	// A result leaves only when it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(res_valid) |-> $past(!res_stall))
		else $error("result withdrawn without being taken");

endmodule

bind edge_non_maximum_suppression_core enms_assertions u_enms_assertions (.*);
